// File: hdl/line_segment_window_clip_top_macros.svh
// Assertion macros shared by the line clip checker.
`ifndef LINE_SEGMENT_WINDOW_CLIP_TOP_MACROS_SVH
`define LINE_SEGMENT_WINDOW_CLIP_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define LSWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define LSWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/lswc_pkg.sv
// Package with outcode type, outcode bits, register indexes and round limit.
`timescale 1ns / 1ps
package lswc_pkg;

  typedef logic [3:0] outcode_t;

  localparam outcode_t CODE_LEFT   = 4'b0001;
  localparam outcode_t CODE_RIGHT  = 4'b0010;
  localparam outcode_t CODE_BOTTOM = 4'b0100;
  localparam outcode_t CODE_TOP    = 4'b1000;

  localparam int CFG_INDEX_WIDTH = 2;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t REG_LEFT   = 2'd0;
  localparam cfg_index_t REG_BOTTOM = 2'd1;
  localparam cfg_index_t REG_RIGHT  = 2'd2;
  localparam cfg_index_t REG_TOP    = 2'd3;

  localparam int ROUND_WIDTH = 3;
  localparam logic [ROUND_WIDTH-1:0] MAX_ROUNDS = 3'd4;

  // Builds an outcode from the four window compares.
  function automatic outcode_t make_code(input logic left_out, input logic right_out,
                                         input logic bottom_out, input logic top_out);
    outcode_t c;
    c = '0;
    if (left_out)   c = c | CODE_LEFT;
    if (right_out)  c = c | CODE_RIGHT;
    if (bottom_out) c = c | CODE_BOTTOM;
    if (top_out)    c = c | CODE_TOP;
    return c;
  endfunction

endpackage

// File: hdl/lswc_fifo.sv
// Two-entry queue between the classifier front and the clipping engine.
`timescale 1ns / 1ps
module lswc_fifo #(
  parameter int WIDTH = 72
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !full) begin
      wr_ptr_nxt = ~wr_ptr_r;
      count_nxt  = count_nxt + 2'd1;
    end
    if (rd_en && !empty) begin
      rd_ptr_nxt = ~rd_ptr_r;
      count_nxt  = count_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (wr_en && !full) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end
endmodule

// File: hdl/lswc_front.sv
// Front end: computes both endpoint outcodes and packs the queue entry.
`timescale 1ns / 1ps
module lswc_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] win_left,
  input  logic signed [COORD_WIDTH-1:0] win_bottom,
  input  logic signed [COORD_WIDTH-1:0] win_right,
  input  logic signed [COORD_WIDTH-1:0] win_top,
  output logic [4*COORD_WIDTH+7:0]      entry
);
  import lswc_pkg::*;

  outcode_t code_start;
  outcode_t code_end;

  assign code_start = make_code(start_x < win_left, start_x > win_right,
                                start_y < win_bottom, start_y > win_top);
  assign code_end   = make_code(end_x < win_left, end_x > win_right,
                                end_y < win_bottom, end_y > win_top);

  assign entry = {start_x, start_y, end_x, end_y, code_start, code_end};
endmodule

// File: hdl/lswc_engine.sv
// Clipping engine: edge selection, multiply, serial divide and result register.
`timescale 1ns / 1ps
module lswc_engine #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [4*COORD_WIDTH+7:0]      entry,
  input  logic                          entry_empty,
  output logic                          entry_pop,
  input  logic signed [COORD_WIDTH-1:0] win_left,
  input  logic signed [COORD_WIDTH-1:0] win_bottom,
  input  logic signed [COORD_WIDTH-1:0] win_right,
  input  logic signed [COORD_WIDTH-1:0] win_top,
  output logic                          res_empty,
  input  logic                          res_pop,
  output logic                          res_visible,
  output logic signed [COORD_WIDTH-1:0] res_start_x,
  output logic signed [COORD_WIDTH-1:0] res_start_y,
  output logic signed [COORD_WIDTH-1:0] res_end_x,
  output logic signed [COORD_WIDTH-1:0] res_end_y
);
  import lswc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int W1 = COORD_WIDTH + 1;
  localparam int CW = $clog2(W1 + 1);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_MUL, S_DIV, S_UPDATE} state_t;

  state_t                 state_r;
  logic signed [W-1:0]    x1_r, y1_r, x2_r, y2_r;
  outcode_t               c1_r, c2_r;
  logic [ROUND_WIDTH-1:0] round_r;
  logic signed [W-1:0]    edge_r, base_r;
  logic                   horiz_r, second_r;
  logic signed [W1-1:0]   dp_r, num_r, dq_r;
  logic [W1-1:0]          ud_r, rem_r, quo_r;
  logic                   neg_r;
  logic [CW-1:0]          cnt_r;
  logic                   valid_r;

  // Edge selection for the current round.
  outcode_t             cout;
  logic signed [W-1:0]  sel_edge, sel_base;
  logic signed [W1-1:0] sel_dp, sel_num, sel_dq;
  logic                 sel_horiz;
  logic signed [W1-1:0] dx, dy;

  assign dx   = W1'(x2_r) - W1'(x1_r);
  assign dy   = W1'(y2_r) - W1'(y1_r);
  assign cout = (c1_r != '0) ? c1_r : c2_r;

  always_comb begin
    sel_horiz = 1'b1;
    sel_edge  = win_top;
    sel_base  = x1_r;
    sel_dp    = dx;
    sel_dq    = dy;
    sel_num   = W1'(win_top) - W1'(y1_r);
    if ((cout & CODE_TOP) != '0) begin
      sel_edge = win_top;
    end else if ((cout & CODE_BOTTOM) != '0) begin
      sel_edge = win_bottom;
      sel_num  = W1'(win_bottom) - W1'(y1_r);
    end else if ((cout & CODE_RIGHT) != '0) begin
      sel_horiz = 1'b0;
      sel_edge  = win_right;
      sel_base  = y1_r;
      sel_dp    = dy;
      sel_dq    = dx;
      sel_num   = W1'(win_right) - W1'(x1_r);
    end else begin
      sel_horiz = 1'b0;
      sel_edge  = win_left;
      sel_base  = y1_r;
      sel_dp    = dy;
      sel_dq    = dx;
      sel_num   = W1'(win_left) - W1'(x1_r);
    end
  end

  // Magnitudes and product.
  logic [W1-1:0]   ua, ub, uc;
  logic [2*W1-1:0] prod;
  assign ua   = dp_r[W1-1]  ? W1'(-dp_r)  : W1'(dp_r);
  assign ub   = num_r[W1-1] ? W1'(-num_r) : W1'(num_r);
  assign uc   = dq_r[W1-1]  ? W1'(-dq_r)  : W1'(dq_r);
  assign prod = ua * ub;

  // One restoring division step.
  logic [W1:0] rem_sh, rem_sub;
  logic        ge;
  assign rem_sh  = {rem_r, quo_r[W1-1]};
  assign ge      = rem_sh >= {1'b0, ud_r};
  assign rem_sub = rem_sh - {1'b0, ud_r};

  // New crossing point.
  logic [W1-1:0]        q;
  logic signed [W1:0]   qs, sum;
  logic signed [W-1:0]  nc, nx, ny;
  outcode_t             ncode;
  assign q     = (ud_r == '0) ? '0 : quo_r;
  assign qs    = neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
  assign sum   = (W1 + 1)'(base_r) + qs;
  assign nc    = sum[W-1:0];
  assign nx    = horiz_r ? nc : edge_r;
  assign ny    = horiz_r ? edge_r : nc;
  assign ncode = make_code(nx < win_left, nx > win_right, ny < win_bottom, ny > win_top);

  assign entry_pop   = (state_r == S_IDLE) && !entry_empty && !valid_r;
  assign res_empty   = !valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      if (valid_r && res_pop) begin
        valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (entry_pop) begin
            {x1_r, y1_r, x2_r, y2_r, c1_r, c2_r} <= entry;
            round_r <= '0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (c1_r == '0 && c2_r == '0) begin
            valid_r     <= 1'b1;
            res_visible <= 1'b1;
            res_start_x <= x1_r;
            res_start_y <= y1_r;
            res_end_x   <= x2_r;
            res_end_y   <= y2_r;
            state_r     <= S_IDLE;
          end else if ((c1_r & c2_r) != '0 || round_r == MAX_ROUNDS) begin
            valid_r     <= 1'b1;
            res_visible <= 1'b0;
            res_start_x <= '0;
            res_start_y <= '0;
            res_end_x   <= '0;
            res_end_y   <= '0;
            state_r     <= S_IDLE;
          end else begin
            edge_r   <= sel_edge;
            base_r   <= sel_base;
            horiz_r  <= sel_horiz;
            second_r <= (c1_r == '0);
            dp_r     <= sel_dp;
            num_r    <= sel_num;
            dq_r     <= sel_dq;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          // The quotient fits W1 bits, so the upper half starts as the remainder.
          rem_r   <= prod[2*W1-1:W1];
          quo_r   <= prod[W1-1:0];
          ud_r    <= uc;
          neg_r   <= (dp_r[W1-1] ^ num_r[W1-1] ^ dq_r[W1-1]) && ua != '0 && ub != '0;
          cnt_r   <= CW'(W1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? rem_sub[W1-1:0] : rem_sh[W1-1:0];
          quo_r <= {quo_r[W1-2:0], ge};
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (second_r) begin
            x2_r <= nx;
            y2_r <= ny;
            c2_r <= ncode;
          end else begin
            x1_r <= nx;
            y1_r <= ny;
            c1_r <= ncode;
          end
          round_r <= round_r + ROUND_WIDTH'(1);
          state_r <= S_CHECK;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/line_segment_window_clip_top.sv
// Top level of the Cohen-Sutherland line segment window clipper.
`timescale 1ns / 1ps
// Clips one segment per item against a window held in four registers and
// returns a visible flag with the clipped endpoints, one result per item.
// Items go through a two-entry queue to a single clipping engine that
// handles one segment at a time. A segment that is trivially accepted or
// rejected reaches the result register once the engine has popped it from
// the queue in S_IDLE and classified it in S_CHECK. Each clip round, of
// which there are at most four, has a classify step, a multiply step,
// COORD_WIDTH + 1 divide steps that each retire one quotient bit, and an
// update step. The result register frees only when the result item is
// popped, and the engine takes the next item from the queue in the cycle
// after that. Configuration writes are always ready and should be made
// while idle.
module line_segment_window_clip_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [COORD_WIDTH-1:0]        in_start_x,
  input  logic signed [COORD_WIDTH-1:0]        in_start_y,
  input  logic signed [COORD_WIDTH-1:0]        in_end_x,
  input  logic signed [COORD_WIDTH-1:0]        in_end_y,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic                                 out_visible,
  output logic signed [COORD_WIDTH-1:0]        out_clip_start_x,
  output logic signed [COORD_WIDTH-1:0]        out_clip_start_y,
  output logic signed [COORD_WIDTH-1:0]        out_clip_end_x,
  output logic signed [COORD_WIDTH-1:0]        out_clip_end_y,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  lswc_pkg::cfg_index_t                 cfg_index,
  input  logic [COORD_WIDTH-1:0]               cfg_data
);
  import lswc_pkg::*;

  localparam int EW = 4 * COORD_WIDTH + 8;

  logic signed [COORD_WIDTH-1:0] win_left_r, win_bottom_r, win_right_r, win_top_r;
  logic [EW-1:0] front_entry, queue_entry;
  logic          queue_empty, queue_pop;

  assign cfg_ready = 1'b1;

  // Window registers reset to a 201 by 201 square around the origin.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= -COORD_WIDTH'(100);
      win_bottom_r <= -COORD_WIDTH'(100);
      win_right_r  <= COORD_WIDTH'(100);
      win_top_r    <= COORD_WIDTH'(100);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEFT:   win_left_r   <= cfg_data;
        REG_BOTTOM: win_bottom_r <= cfg_data;
        REG_RIGHT:  win_right_r  <= cfg_data;
        REG_TOP:    win_top_r    <= cfg_data;
        default:    win_left_r   <= win_left_r;
      endcase
    end
  end

  lswc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .end_x      (in_end_x),
    .end_y      (in_end_y),
    .win_left   (win_left_r),
    .win_bottom (win_bottom_r),
    .win_right  (win_right_r),
    .win_top    (win_top_r),
    .entry      (front_entry)
  );

  lswc_fifo #(.WIDTH(EW)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (front_entry),
    .full    (in_full),
    .rd_en   (queue_pop),
    .rd_data (queue_entry),
    .empty   (queue_empty)
  );

  lswc_engine #(.COORD_WIDTH(COORD_WIDTH)) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry       (queue_entry),
    .entry_empty (queue_empty),
    .entry_pop   (queue_pop),
    .win_left    (win_left_r),
    .win_bottom  (win_bottom_r),
    .win_right   (win_right_r),
    .win_top     (win_top_r),
    .res_empty   (out_empty),
    .res_pop     (out_pop),
    .res_visible (out_visible),
    .res_start_x (out_clip_start_x),
    .res_start_y (out_clip_start_y),
    .res_end_x   (out_clip_end_x),
    .res_end_y   (out_clip_end_y)
  );
endmodule

// File: hdl/lswc_checker.sv
// Port-level checker for the line clipper and its bind to the top level.
`timescale 1ns / 1ps
`include "line_segment_window_clip_top_macros.svh"
module lswc_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_full,
  input logic                   out_empty,
  input logic                   out_pop,
  input logic                   out_visible,
  input logic [COORD_WIDTH-1:0] out_clip_start_x,
  input logic [COORD_WIDTH-1:0] out_clip_start_y,
  input logic [COORD_WIDTH-1:0] out_clip_end_x,
  input logic [COORD_WIDTH-1:0] out_clip_end_y,
  input logic                   cfg_ready
);
  // Reset leaves no result waiting and room for input.
  `LSWC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (out_empty && !in_full), "not empty after reset")
  // A hidden segment reports all-zero endpoints.
  `LSWC_ASSERT(a_hidden_zero, (!out_empty && !out_visible) |-> (out_clip_start_x == '0 && out_clip_start_y == '0 && out_clip_end_x == '0 && out_clip_end_y == '0), "hidden result not zero")
  // A waiting result stays, with its visible flag and start x unchanged, until popped.
  `LSWC_ASSERT(a_result_held, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_visible) && $stable(out_clip_start_x)), "result changed before pop")
  // The register port never stalls.
  `LSWC_ASSERT(a_cfg_ready, cfg_ready, "configuration port stalled")
endmodule

bind line_segment_window_clip_top lswc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lswc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_visible      (out_visible),
  .out_clip_start_x (out_clip_start_x),
  .out_clip_start_y (out_clip_start_y),
  .out_clip_end_x   (out_clip_end_x),
  .out_clip_end_y   (out_clip_end_y),
  .cfg_ready        (cfg_ready)
);
